FILE: hw/rtl/prsi_pkg.sv
// Shared types and constants for the pixel rescale (slope/intercept) block.
`timescale 1ns / 1ps

package prsi_pkg;

  // Fixed field widths
  localparam int RAW_W    = 16;   // raw sample word
  localparam int SMP_W    = 17;   // sample after sign/zero extension
  localparam int SLOPE_W  = 32;
  localparam int ICPT_W   = 40;
  localparam int PROD_W   = SMP_W + SLOPE_W;   // exact product
  localparam int ACC_W    = PROD_W + 1;        // product plus intercept
  localparam int PIX_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ICPT_W;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIXTEEN_BIT = 3'd0,
    REG_SIGNED      = 3'd1,
    REG_SLOPE       = 3'd2,
    REG_INTERCEPT   = 3'd3
  } cfg_reg_t;

  // One finished result
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic                    sat;
  } pix_res_t;

endpackage

FILE: hw/rtl/prsi_round_sat.sv
// Round-half-away-from-zero and 16-bit saturation of the fixed-point sum.
`timescale 1ns / 1ps

module prsi_round_sat
  import prsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [ACC_W-1:0] acc,
  output pix_res_t                res
);

  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam int               TOP  = FRAC_BITS + PIX_W - 1;

  logic [ACC_W-1:0] rnd;
  logic             sat_hi;
  logic             sat_lo;

  // Negative sums take half minus one so that the arithmetic shift
  // rounds ties away from zero.
  always_comb begin
    rnd    = acc[ACC_W-1] ? (acc + HALF - ACC_W'(1)) : (acc + HALF);
    sat_hi = !rnd[ACC_W-1] && (|rnd[ACC_W-2:TOP]);
    sat_lo =  rnd[ACC_W-1] && !(&rnd[ACC_W-2:TOP]);
    res.sat = sat_hi || sat_lo;
    if (sat_hi) begin
      res.pixel = PIX_MAX;
    end else if (sat_lo) begin
      res.pixel = PIX_MIN;
    end else begin
      res.pixel = rnd[TOP:FRAC_BITS];
    end
  end

endmodule

FILE: hw/rtl/pixel_rescale_slope_intercept.sv
// Top level: modality rescale pixel = raw * slope + intercept, rounded and saturated.
`timescale 1ns / 1ps
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid / in_stall   in_raw_sample[15:0]
//   out_     source     out_valid / out_stall out_pixel_value[15:0] s, out_saturated
//   cfg_     sink       cfg_valid / cfg_ready cfg_index[2:0], cfg_data[39:0]
//
// One beat per clock while out_stall is low; four register stages (extend,
// multiply, add intercept, round/saturate), and a beat taken in passes through
// them in that order into the output register, from which it can leave.
// The 17x32 multiplier in stage two sets the clock budget.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults: 16-bit mode, unsigned, slope 1.0, intercept 0.
// A stalled output holds its beat; stages behind it keep filling bubbles and
// in_stall rises only once every stage holds a beat.
// cfg_ready is always high; write registers only while the pipeline is empty.

module pixel_rescale_slope_intercept
  import prsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [RAW_W-1:0]             in_raw_sample,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PIX_W-1:0]      out_pixel_value,
  output logic                         out_saturated,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam logic signed [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                      mode16_r;
  logic                      signed_r;
  logic signed [SLOPE_W-1:0] slope_r;     // zero already replaced by 1.0
  logic signed [ICPT_W-1:0]  icpt_r;
  logic                      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode16_r <= 1'b1;
      signed_r <= 1'b0;
      slope_r  <= SLOPE_ONE;
      icpt_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIXTEEN_BIT: mode16_r <= cfg_data[0];
        REG_SIGNED:      signed_r <= cfg_data[0];
        // A zero slope means unity; fold that in once here.
        REG_SLOPE:       slope_r  <= (cfg_data[SLOPE_W-1:0] == '0) ?
                                     SLOPE_ONE : cfg_data[SLOPE_W-1:0];
        REG_INTERCEPT:   icpt_r   <= cfg_data[ICPT_W-1:0];
        default: ;       // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage loads when empty or when the stage ahead
  // loads, so bubbles collapse and a stalled output backs up one stage at a time.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic ld1, ld2, ld3, ld_out;

  assign ld_out   = !out_valid_r || !out_stall;
  assign ld3      = !s3_v_r || ld_out;
  assign ld2      = !s2_v_r || ld3;
  assign ld1      = !s1_v_r || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1)    s1_v_r      <= in_valid;
      if (ld2)    s2_v_r      <= s1_v_r;
      if (ld3)    s3_v_r      <= s2_v_r;
      if (ld_out) out_valid_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0]  s1_raw_r, s1_raw_nxt;
  logic signed [PROD_W-1:0] s2_prod_r, s2_prod_nxt;
  logic signed [ACC_W-1:0]  s3_acc_r, s3_acc_nxt;
  pix_res_t                 res_nxt;
  pix_res_t                 out_res_r;
  logic                     smp_sign;

  // Stage 1: pick the byte or word and extend it to 17 signed bits.
  always_comb begin
    if (mode16_r) begin
      smp_sign   = signed_r && in_raw_sample[RAW_W-1];
      s1_raw_nxt = {smp_sign, in_raw_sample};
    end else begin
      smp_sign   = signed_r && in_raw_sample[7];
      s1_raw_nxt = {{(SMP_W-8){smp_sign}}, in_raw_sample[7:0]};
    end
  end

  // Stage 2: exact product. Stage 3: add intercept.
  assign s2_prod_nxt = PROD_W'(s1_raw_r) * PROD_W'(slope_r);
  assign s3_acc_nxt  = ACC_W'(s2_prod_r) + ACC_W'(icpt_r);

  // Stage 4: round and clamp into the output register.
  prsi_round_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round_sat (
    .acc (s3_acc_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld1)    s1_raw_r  <= s1_raw_nxt;
    if (ld2)    s2_prod_r <= s2_prod_nxt;
    if (ld3)    s3_acc_r  <= s3_acc_nxt;
    if (ld_out) out_res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_res_r.pixel;
  assign out_saturated   = out_res_r.sat;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input backs up only when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && out_valid_r))
    else $error("in_stall with an empty pipeline stage");

  // A free-running output never stalls the input.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall while output is not stalled");

  // With no backpressure an accepted beat reaches out_ without being held in any stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted beat did not reach the output on time");

  // A clamped result carries one of the two range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_pixel_value == PIX_MAX || out_pixel_value == PIX_MIN))
    else $error("saturated flag with an unclamped value");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the pixel rescale (slope/intercept) block.
`timescale 1ns / 1ps

module tb;
  import prsi_pkg::*;

  localparam int     FRAC         = 16;
  localparam int     PIPE_LAT     = 4;     // register stages in the pipeline
  localparam int     MAX_GAP      = 18;    // longest random idle burst
  localparam int     LONG_HOLD    = 60;    // receiver hold-off that fills the pipe
  localparam int     DRAIN_LIMIT  = 4000;  // cycles to wait for outstanding beats
  localparam int     PHASE_ITEMS  = 60;
  localparam int     RAND_PHASES  = 7;
  localparam longint RUN_LIMIT_NS = 3_000_000;

  localparam logic [SLOPE_W-1:0] SLOPE_ONE  = SLOPE_W'(1) << FRAC;
  localparam logic [SLOPE_W-1:0] SLOPE_HALF = SLOPE_W'(1) << (FRAC - 1);

  // Sample words that sit on the edges of both byte and word modes
  localparam logic [RAW_W-1:0] EDGE_WORDS [8] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
    16'h00FF, 16'h0080, 16'h007F, 16'hFF00
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_W-1:0]      in_raw_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [PIX_W-1:0] out_pixel_value;
  logic                  out_saturated;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the register file, loaded with the reset defaults
  logic                  cfg_wide   = 1'b1;
  logic                  cfg_signed = 1'b0;
  logic [SLOPE_W-1:0]    cfg_slope  = SLOPE_ONE;
  logic [ICPT_W-1:0]     cfg_icpt   = '0;

  pix_res_t pending_pixels[$];   // rescaled pixels still to come out, oldest first
  int       error_count = 0;
  bit       idle_on     = 1'b1;  // sender inserts random gaps
  bit       stall_on    = 1'b1;  // receiver inserts random stalls
  bit       hold_request = 1'b0; // ask the receiver for one long hold-off

  pixel_rescale_slope_intercept #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_value(out_pixel_value),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #RUN_LIMIT_NS;
    $display("Some tests failed");
    $finish;
  end

  // Rescale one raw word under the shadow registers: extend, multiply-add
  // exactly, round half away from zero, then clamp to the pixel range.
  function automatic pix_res_t rescale_pixel(input logic [RAW_W-1:0] word);
    longint   smp;
    longint   slope;
    longint   acc;
    longint   mag;
    longint   q;
    longint   r;
    pix_res_t res;
    if (cfg_wide)
      smp = cfg_signed ? longint'($signed(word)) : longint'(word);
    else
      smp = cfg_signed ? longint'($signed(word[7:0])) : longint'(word[7:0]);
    slope = longint'($signed(cfg_slope));
    // a zero slope stands for 1.0
    if (slope == 0)
      slope = longint'(1) << FRAC;
    acc = smp * slope + longint'($signed(cfg_icpt));
    mag = (acc < 0) ? -acc : acc;
    q   = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
    r   = (acc < 0) ? -q : q;
    res.sat = 1'b0;
    // judge saturation on the rounded integer
    if (r > longint'(PIX_MAX)) begin
      r = longint'(PIX_MAX);
      res.sat = 1'b1;
    end else if (r < longint'(PIX_MIN)) begin
      r = longint'(PIX_MIN);
      res.sat = 1'b1;
    end
    res.pixel = PIX_W'(r);
    return res;
  endfunction

  // Offer one sample beat and hold it until accepted; then record the
  // expected pixel and maybe drop valid for a random burst.
  task automatic send_pixel(input logic [RAW_W-1:0] word);
    in_valid      <= 1'b1;
    in_raw_sample <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.insert(pending_pixels.size(), rescale_pixel(word));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // Write one register; valid stays high so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SIXTEEN_BIT: cfg_wide   = data[0];
      REG_SIGNED:      cfg_signed = data[0];
      REG_SLOPE:       cfg_slope  = data[SLOPE_W-1:0];
      REG_INTERCEPT:   cfg_icpt   = data[ICPT_W-1:0];
      default: ;
    endcase
  endtask

  // Load all four registers. Fill unused upper bits with noise so that
  // truncation is exercised, and poke one index past the register map.
  task automatic load_config(input logic wide, input logic sgn,
                             input logic [SLOPE_W-1:0] slope,
                             input logic [ICPT_W-1:0] icpt);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_SIXTEEN_BIT, {noise[CFG_DATA_W-1:1], wide});
    noise = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_SIGNED, {noise[CFG_DATA_W-1:1], sgn});
    noise = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_SLOPE, {noise[CFG_DATA_W-1:SLOPE_W], slope});
    write_reg(REG_INTERCEPT, icpt);
    write_reg(CFG_IDX_W'($urandom_range(REG_INTERCEPT + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait for every outstanding pixel, then let the
  // pipeline settle so the registers can be rewritten safely.
  task automatic drain_pipeline();
    int k;
    in_valid <= 1'b0;
    k = 0;
    while (pending_pixels.size() > 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    if (pending_pixels.size() > 0) begin
      $error("%0d pixel beats never arrived", pending_pixels.size());
      error_count += pending_pixels.size();
      pending_pixels.delete();
    end
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted output beat against the oldest expected pixel
  always @(posedge clk) begin : check_results
    pix_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel beat: pixel_value %0d, saturated %0b",
               out_pixel_value, out_saturated);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_value !== want.pixel) begin
          $error("pixel_value: expected %0d, got %0d", want.pixel, out_pixel_value);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // Reset defaults: 16-bit unsigned with unit slope; then signed words
  task automatic test_reset_defaults();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    drain_pipeline();
    load_config(1'b1, 1'b1, SLOPE_ONE, '0);
    send_pixel(16'h8000);
    send_pixel(16'hFFFF);
    drain_pipeline();
  endtask

  // Byte mode: ignore the high byte, both signednesses
  task automatic test_byte_mode();
    load_config(1'b0, 1'b0, SLOPE_ONE, '0);
    send_pixel(16'hFF00);
    send_pixel(16'h00FF);
    send_pixel(16'hAB80);
    drain_pipeline();
    load_config(1'b0, 1'b1, SLOPE_ONE, '0);
    send_pixel(16'h0080);
    send_pixel(16'hFF7F);
    send_pixel(16'h00FF);
    drain_pipeline();
  endtask

  // Half slope puts odd samples exactly on halves; round away from zero
  task automatic test_round_halves();
    load_config(1'b1, 1'b1, SLOPE_HALF, '0);
    send_pixel(16'd5);
    send_pixel(16'hFFFB);
    send_pixel(16'd1);
    send_pixel(16'hFFFF);
    drain_pipeline();
  endtask

  // Zero slope acts as 1.0; intercept of 1.0 on top
  task automatic test_zero_slope();
    load_config(1'b1, 1'b0, '0, ICPT_W'(1) << FRAC);
    send_pixel(16'd1234);
    send_pixel(16'h0000);
    drain_pipeline();
  endtask

  // Extreme registers, and rounded values just inside and just past the range
  task automatic test_saturation();
    load_config(1'b1, 1'b0, 32'h7FFF_FFFF, 40'h7F_FFFF_FFFF);
    send_pixel(16'hFFFF);
    drain_pipeline();
    load_config(1'b1, 1'b1, 32'h8000_0000, 40'h80_0000_0000);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    drain_pipeline();
    // 32767.4 stays unflagged, 32767.5 rounds up and clamps
    load_config(1'b1, 1'b0, SLOPE_ONE, ICPT_W'(26214));
    send_pixel(16'h7FFF);
    drain_pipeline();
    load_config(1'b1, 1'b0, SLOPE_ONE, ICPT_W'(32768));
    send_pixel(16'h7FFF);
    drain_pipeline();
    // -32768.5 rounds to -32769 and clamps; -32768.49 does not
    load_config(1'b1, 1'b1, SLOPE_ONE, 40'hFF_FFFF_8000);
    send_pixel(16'h8000);
    drain_pipeline();
    load_config(1'b1, 1'b1, SLOPE_ONE, 40'hFF_FFFF_8001);
    send_pixel(16'h8000);
    drain_pipeline();
  endtask

  // Hold the output off long enough that in_stall must rise while the
  // sender keeps offering back-to-back beats; then pause for a full drain.
  task automatic test_backpressure();
    load_config(1'b1, 1'b1, SLOPE_W'(int'($urandom_range(0, 4 << FRAC)) - (2 << FRAC)),
                ICPT_W'(longint'($signed($urandom)) >>> 3));
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (30) send_pixel(RAW_W'($urandom));
    idle_on = 1'b1;
    drain_pipeline();
  endtask

  // One phase: random register setting, then a run of random samples
  task automatic run_random_phase(input int items);
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
    case ($urandom_range(0, 7))
      0:       slope = 32'h7FFF_FFFF;
      1:       slope = 32'h8000_0000;
      2:       slope = '0;
      3:       slope = $urandom;
      default: slope = SLOPE_W'(int'($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
    endcase
    case ($urandom_range(0, 7))
      0:       icpt = 40'h7F_FFFF_FFFF;
      1:       icpt = 40'h80_0000_0000;
      2:       icpt = ICPT_W'({$urandom, $urandom});
      default: icpt = ICPT_W'(longint'($signed($urandom)) >>> 3);
    endcase
    load_config(1'($urandom), 1'($urandom), slope, icpt);
    repeat (items) begin
      if ($urandom_range(0, 4) == 0)
        send_pixel(EDGE_WORDS[$urandom_range(0, 7)]);
      else
        send_pixel(RAW_W'($urandom));
    end
    drain_pipeline();
  endtask

  task automatic test_random();
    repeat (RAND_PHASES) run_random_phase(PHASE_ITEMS);
    // last stretch: no idling on either side
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_random_phase(PHASE_ITEMS);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_raw_sample = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_byte_mode();
    test_round_halves();
    test_zero_slope();
    test_saturation();
    test_backpressure();
    test_random();

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/prsi_pkg.sv
hw/rtl/prsi_round_sat.sv
hw/rtl/pixel_rescale_slope_intercept.sv
tb/tb.sv
